// ===== src/rpd_pkg.sv =====
package rpd_pkg;

   // default pool depth
   localparam int MaxCellsDefault = 256;

   // field widths
   localparam int SideWidth = 5;
   localparam int WordWidth = 31;
   localparam int TileWidth = 8;
   localparam int PosWidth  = 4;

   // board side limits and reset value
   localparam logic [SideWidth-1:0] SideReset = 5'd3;
   localparam logic [SideWidth-1:0] SideMin   = 5'd1;
   localparam logic [SideWidth-1:0] SideMax   = 5'd16;

   // width of the square of the largest side
   localparam int CellsWidth = 9;

   // opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

endpackage

// ===== src/random_permutation_drawer.sv =====
// random_permutation_drawer: deals a random permutation of 0 .. side*side-1,
// one tile per draw word, using the swap-with-last shuffle over a pool memory.
// csr_ channel: write board_side (valid/ready, always ready); the side is
// latched by the next start, so write it only while the block is idle.
// req_ channel: opcode start refills the pool with the identity and gives no
// word on rsp_; opcode draw reduces random_word modulo the remaining count,
// returns the pooled tile with its row, column and last flag, then moves the
// last pool entry into the hole. A draw with an empty pool returns nothing.
// Timing: after acceptance a start holds req_stall while it fills cells =
// min(side*side, MAX_CELLS) pool entries, one pool write per cycle. A draw
// runs the restoring divider, one bit of the random word per cycle, then
// two pool reads and one pool write on the memory. One item is worked on at
// a time; req_stall is high from acceptance until the item is done.
// rsp_ has an output register: while it is stalled the finished word holds,
// and the next item may be accepted; a draw that finishes meanwhile waits in
// its write step until the register frees up.
// Reset (synchronous, active high) empties the pool count, clears row and
// column, sets board_side to 3; no clearing pass runs over the pool memory.
module random_permutation_drawer #(
   parameter int MAX_CELLS = rpd_pkg::MaxCellsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpd_pkg::SideWidth-1:0]   csr_board_side,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [rpd_pkg::WordWidth-1:0]   req_random_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rpd_pkg::TileWidth-1:0]   rsp_tile_value,
   output logic [rpd_pkg::PosWidth-1:0]    rsp_cell_row,
   output logic [rpd_pkg::PosWidth-1:0]    rsp_cell_column,
   output logic                            rsp_last_cell
);

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int RW = $clog2(MAX_CELLS + 1);
   localparam int CW = (RW > rpd_pkg::CellsWidth) ? RW : rpd_pkg::CellsWidth;
   localparam int BW = $clog2(rpd_pkg::WordWidth);
   localparam int TW = rpd_pkg::TileWidth;
   localparam int SW = rpd_pkg::SideWidth;
   localparam int PW = rpd_pkg::PosWidth;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DIVIDE,
      ST_READ_SLOT,
      ST_READ_LAST,
      ST_WRITE
   } state_type;

   state_type        state_ff;
   logic [SW-1:0]    board_side_ff;
   logic [SW-1:0]    active_side_ff;
   logic [RW-1:0]    remaining_ff;
   logic [RW-1:0]    fill_ff;
   logic [RW-1:0]    rem_ff;
   logic [rpd_pkg::WordWidth-1:0] word_ff;
   logic [BW-1:0]    bit_cnt_ff;
   logic [PW-1:0]    row_ff;
   logic [PW-1:0]    col_ff;
   logic [TW-1:0]    tile_ff;
   logic [TW-1:0]    rd_data_ff;
   logic             rsp_valid_ff;
   logic [TW-1:0]    rsp_tile_ff;
   logic [PW-1:0]    rsp_row_ff;
   logic [PW-1:0]    rsp_col_ff;
   logic             rsp_last_ff;

   logic [TW-1:0]    pool_mem [MAX_CELLS];

   // start-time cell count
   logic [SW-1:0]    side_in;
   logic [rpd_pkg::CellsWidth-1:0] cells_full;
   logic [CW-1:0]    cells_sat;

   // divider step
   logic [RW:0]      trial;
   logic [RW:0]      trial_diff;
   logic [RW-1:0]    rem_in;

   logic             req_accept;
   logic             out_free;
   logic             advance;
   logic [AW-1:0]    slot_addr;
   logic [AW-1:0]    last_addr;
   logic [AW-1:0]    mem_raddr;
   logic [AW-1:0]    mem_waddr;
   logic [TW-1:0]    mem_wdata;
   logic             mem_we;
   logic [SW-1:0]    col_next;

   always_comb begin
      if (board_side_ff < rpd_pkg::SideMin) begin
         side_in = rpd_pkg::SideMin;
      end else if (board_side_ff > rpd_pkg::SideMax) begin
         side_in = rpd_pkg::SideMax;
      end else begin
         side_in = board_side_ff;
      end
   end

   assign cells_full = rpd_pkg::CellsWidth'(side_in) * rpd_pkg::CellsWidth'(side_in);
   assign cells_sat  = (CW'(cells_full) > CW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cells_full);

   assign trial      = {rem_ff, word_ff[rpd_pkg::WordWidth-1]};
   assign trial_diff = trial - {1'b0, remaining_ff};
   assign rem_in     = (trial >= {1'b0, remaining_ff}) ? trial_diff[RW-1:0] : trial[RW-1:0];

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = (state_ff == ST_WRITE) && out_free;
   assign slot_addr  = rem_ff[AW-1:0];
   assign last_addr  = AW'(remaining_ff - RW'(1));
   assign col_next   = SW'(col_ff) + SW'(1);

   always_comb begin
      mem_raddr = slot_addr;
      mem_waddr = slot_addr;
      mem_wdata = rd_data_ff;
      mem_we    = 1'b0;
      case (state_ff)
         ST_FILL: begin
            mem_waddr = fill_ff[AW-1:0];
            mem_wdata = TW'(fill_ff);
            mem_we    = 1'b1;
         end
         ST_READ_LAST: begin
            mem_raddr = last_addr;
         end
         ST_WRITE: begin
            // keep the last entry on the read port while waiting
            mem_raddr = last_addr;
            mem_we    = advance;
         end
         default: begin
            mem_raddr = slot_addr;
         end
      endcase
   end

   // pool memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pool_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         board_side_ff  <= rpd_pkg::SideReset;
         active_side_ff <= rpd_pkg::SideMin;
         remaining_ff   <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            board_side_ff <= csr_board_side;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_opcode == rpd_pkg::OP_START) begin
                     remaining_ff   <= RW'(cells_sat);
                     active_side_ff <= side_in;
                     row_ff         <= '0;
                     col_ff         <= '0;
                     fill_ff        <= '0;
                     state_ff       <= ST_FILL;
                  end else if (remaining_ff != '0) begin
                     word_ff    <= req_random_word;
                     rem_ff     <= '0;
                     bit_cnt_ff <= BW'(rpd_pkg::WordWidth - 1);
                     state_ff   <= ST_DIVIDE;
                  end
               end
            end
            ST_FILL: begin
               fill_ff <= fill_ff + RW'(1);
               if (fill_ff == remaining_ff - RW'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIVIDE: begin
               // restoring division, one word bit per cycle
               rem_ff     <= rem_in;
               word_ff    <= {word_ff[rpd_pkg::WordWidth-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff - BW'(1);
               if (bit_cnt_ff == '0) begin
                  state_ff <= ST_READ_SLOT;
               end
            end
            ST_READ_SLOT: begin
               state_ff <= ST_READ_LAST;
            end
            ST_READ_LAST: begin
               tile_ff  <= rd_data_ff;
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               // last entry fills the hole once the output register is free
               if (advance) begin
                  rsp_tile_ff  <= tile_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_col_ff   <= col_ff;
                  rsp_last_ff  <= (remaining_ff == RW'(1));
                  remaining_ff <= remaining_ff - RW'(1);
                  if (col_next >= active_side_ff) begin
                     col_ff <= '0;
                     row_ff <= row_ff + PW'(1);
                  end else begin
                     col_ff <= col_next[PW-1:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_value  = rsp_tile_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_cell_column = rsp_col_ff;
   assign rsp_last_cell   = rsp_last_ff;

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= RW'(MAX_CELLS))
      else $error("remaining count above pool depth");

   a_divide_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < remaining_ff))
      else $error("partial remainder not below divisor");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      (SW'(col_ff) < active_side_ff))
      else $error("column counter beyond latched side");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && remaining_ff == RW'(1)) |=> (remaining_ff == '0 && rsp_last_cell))
      else $error("last cell did not empty the pool");

endmodule
